FILE: rtl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg: shared types and constants for the LEB128 / zigzag decoder
// Result codes, register indexes and the step result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lzsd_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned GROUP_W   = 7;
    localparam int unsigned INDEX_W   = 4;
    localparam logic [INDEX_W-1:0] LAST_GROUP = 4'd9;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_LONG     = 2'd1,
        ST_NOT_SHORTEST = 2'd2,
        ST_ABOVE_MAX    = 2'd3
    } status_t;

    typedef enum logic {
        REG_SIGNED_MODE = 1'b0,
        REG_MAX_VALUE   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                 emit;
        logic [VALUE_W-1:0]   value;
        status_t              status;
        logic [VALUE_W-1:0]   partial_next;
        logic [INDEX_W-1:0]   group_next;
    } step_t;

endpackage

`default_nettype wire

FILE: rtl/lzsd_step.sv
// ----------------------------------------------------------------------------
// lzsd_step: one byte of LEB128 decoding
// Merges a 7-bit group into the partial value and, on the final byte,
// classifies the result and applies zigzag decoding or the limit check.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsd_step
    import lzsd_pkg::*;
(
    input  wire logic [7:0]          data_byte,
    input  wire logic [VALUE_W-1:0]  partial_value,
    input  wire logic [INDEX_W-1:0]  group_index,
    input  wire logic                signed_mode,
    input  wire logic [VALUE_W-1:0]  max_value,
    output step_t                    step
);

    logic [GROUP_W-1:0] payload;
    logic               more;
    logic [INDEX_W-1:0] idx;
    logic [5:0]         shift_amt;
    logic [VALUE_W-1:0] placed;
    logic [VALUE_W-1:0] acc;
    logic [VALUE_W-1:0] zigzag;
    logic               too_long;

    assign payload   = data_byte[6:0];
    assign more      = data_byte[7];
    // Clamp an out-of-range index to the last group
    assign idx       = (group_index > LAST_GROUP) ? LAST_GROUP : group_index;
    assign shift_amt = {2'b00, idx} * 6'd7;
    assign placed    = {{(VALUE_W-GROUP_W){1'b0}}, payload} << shift_amt;
    assign acc       = partial_value | placed;
    assign zigzag    = {1'b0, acc[VALUE_W-1:1]} ^ {VALUE_W{acc[0]}};
    assign too_long  = (idx == LAST_GROUP) && (more || (payload > 7'd1));

    always_comb
    begin
        step.emit         = 1'b1;
        step.value        = '0;
        step.status       = ST_OK;
        step.partial_next = '0;
        step.group_next   = '0;
        priority if (too_long)
        begin
            step.status = ST_TOO_LONG;
        end
        else if (more)
        begin
            step.emit         = 1'b0;
            step.partial_next = acc;
            step.group_next   = idx + 4'd1;
        end
        else if ((idx != '0) && (payload == '0))
        begin
            step.status = ST_NOT_SHORTEST;
        end
        else if (signed_mode)
        begin
            step.value = zigzag;
        end
        else if (acc > max_value)
        begin
            step.status = ST_ABOVE_MAX;
        end
        else
        begin
            step.value = acc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/leb128_zigzag_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// leb128_zigzag_stream_decoder_core: streaming LEB128 decoder with zigzag
//
// Bytes arrive on in_valid/in_ready/data_byte, one per request. Every byte
// with bit 7 clear (or a tenth byte that overflows) yields one result on
// out_valid/out_ready with decoded_value and status; other bytes yield none.
// From byte acceptance to result, the byte lands in the input register, then a
// single pass of shift-or, compare and zigzag logic loads the result register.
// One byte is accepted per cycle unless a final byte waits for the receiver.
// When the receiver stalls, the result is held and the input register takes
// one more byte; a continuation byte still advances, a final byte waits.
// Reset clears the partial value, group index and both valid flags, sets
// signed_mode to 0 and max_value to all ones.
// Registers on the APB port: signed_mode at 0x0, max_value at 0x8; write
// them only while the decoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_zigzag_stream_decoder_core
    import lzsd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [63:0]         pwdata,
    output      logic [63:0]         prdata,
    output      logic                pready,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic [7:0]          data_byte,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic [VALUE_W-1:0]  decoded_value,
    output      status_t             status
);

    logic               signed_mode_reg;
    logic [VALUE_W-1:0] max_value_reg;
    logic               cfg_write;
    reg_index_t         cfg_index;

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic [VALUE_W-1:0] partial_reg;
    logic [INDEX_W-1:0] group_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    status_t            status_reg;

    step_t              step;
    logic               slot_free;
    logic               s1_fire;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            REG_SIGNED_MODE: prdata = {63'd0, signed_mode_reg};
            REG_MAX_VALUE:   prdata = max_value_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
            max_value_reg   <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIGNED_MODE: signed_mode_reg <= pwdata[0];
                REG_MAX_VALUE:   max_value_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    lzsd_step u_step (
        .data_byte     (s1_byte_reg),
        .partial_value (partial_reg),
        .group_index   (group_reg),
        .signed_mode   (signed_mode_reg),
        .max_value     (max_value_reg),
        .step          (step)
    );

    // A continuation byte needs no result slot; a final byte does
    assign slot_free = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && (!step.emit || slot_free);
    assign in_ready  = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            partial_reg   <= '0;
            group_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                partial_reg <= step.partial_next;
                group_reg   <= step.group_next;
            end
            if (s1_fire && step.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_fire && step.emit)
        begin
            value_reg  <= step.value;
            status_reg <= step.status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign decoded_value = value_reg;
    assign status        = status_reg;

    // Checks
    a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        group_reg <= LAST_GROUP)
        else $error("group index beyond last group");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> (value_reg == '0))
        else $error("error result carries a non-zero value");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && step.emit |=> (partial_reg == '0) && (group_reg == '0))
        else $error("decoder did not restart after a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && step.emit && out_valid_reg && !out_ready |-> !s1_fire)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: LEB128 / zigzag stream decoder
// Drives encoded bytes through the valid/ready input, predicts each result
// from a local model of the decoder and checks every result in order. It
// covers directed edge cases, register changes through the APB port and a
// long random stream under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench
    import lzsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 4;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } decoded_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [63:0] pwdata    = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] decoded_value;
    status_t     status;

    // local copy of the decoder state and registers
    logic [63:0] acc_value   = '0;
    int          acc_groups  = 0;
    logic        zigzag_on   = 1'b0;
    logic [63:0] value_limit = '1;

    decoded_t    pending_results[$];
    logic [7:0]  burst[$];
    int          errors      = 0;
    int          bytes_sent  = 0;
    int          quiet_cycles = 0;
    logic        calm        = 1'b0;

    leb128_zigzag_stream_decoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .decoded_value (decoded_value),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Work out the result, if any, that one accepted byte causes.
    task automatic decode_step(input logic [7:0] b);
        logic [6:0]  pay;
        logic        more;
        int          idx;
        logic [63:0] v;
        decoded_t    r;
        pay = b[6:0];
        more = b[7];
        idx = (acc_groups > 9) ? 9 : acc_groups;
        if (idx == 9 && (more || pay > 7'd1))
        begin
            r.value = '0;
            r.status = ST_TOO_LONG;
        end
        else
        begin
            acc_value = acc_value | ({57'd0, pay} << (7 * idx));
            if (more)
            begin
                acc_groups = idx + 1;
                return;
            end
            v = acc_value;
            if (idx > 0 && pay == 7'd0)
            begin
                r.value = '0;
                r.status = ST_NOT_SHORTEST;
            end
            else if (zigzag_on)
            begin
                r.value = (v >> 1) ^ {64{v[0]}};
                r.status = ST_OK;
            end
            else if (v > value_limit)
            begin
                r.value = '0;
                r.status = ST_ABOVE_MAX;
            end
            else
            begin
                r.value = v;
                r.status = ST_OK;
            end
        end
        pending_results.insert(pending_results.size(), r);
        acc_value = '0;
        acc_groups = 0;
    endtask

    // Send one byte; entered and left at a rising edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 25) ? $urandom_range(1, 2) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        decode_step(b);
    endtask

    // Append one byte to the burst waiting to be sent.
    task automatic stage_byte(input logic [7:0] b);
        burst.insert(burst.size(), b);
    endtask

    task automatic send_burst();
        foreach (burst[i])
            send_byte(burst[i]);
        burst.delete();
    endtask

    // Shortest-form encoding, or padded with extra zero groups when pad > 0.
    task automatic queue_leb128(input logic [63:0] v, input int pad);
        logic [63:0] r;
        r = v;
        while ((r >> 7) != 0)
        begin
            stage_byte({1'b1, r[6:0]});
            r = r >> 7;
        end
        if (pad == 0)
            stage_byte({1'b0, r[6:0]});
        else
        begin
            stage_byte({1'b1, r[6:0]});
            repeat (pad - 1) stage_byte(8'h80);
            stage_byte(8'h00);
        end
    endtask

    task automatic send_value(input logic [63:0] v);
        queue_leb128(v, 0);
        send_burst();
    endtask

    // Hold the input low until every result is back and the pipe is empty.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [63:0] val);
        logic [3:0] addr;
        addr = {idx, 3'b000};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((idx == REG_SIGNED_MODE) ? (prdata[0] !== val[0]) : (prdata !== val))
        begin
            $display("%0t: register %s readback expected %h actual %h",
                     $time, idx.name(), val, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_SIGNED_MODE)
            zigzag_on = val[0];
        else
            value_limit = val;
    endtask

    task automatic set_mode(input logic sgn, input logic [63:0] lim);
        wait_drain();
        cfg_write(REG_SIGNED_MODE, {63'd0, sgn});
        cfg_write(REG_MAX_VALUE, lim);
    endtask

    function automatic logic [63:0] pick_value();
        int          nbits;
        logic [63:0] mask;
        nbits = $urandom_range(0, 64);
        mask = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
        if (!zigzag_on && $urandom_range(0, 99) < 20)
            return value_limit + 64'($urandom_range(0, 2)) - 64'd1;
        return rand64() & mask;
    endfunction

    // ------------------------------------------------------------------ tests

    task automatic test_plain_values();
        send_value(64'd0);
        send_value(64'd127);
        send_value(64'd128);
        send_value('1);
    endtask

    task automatic test_error_codes();
        // too long: continuation on the tenth byte, then payload above one
        repeat (10) stage_byte(8'h80);
        repeat (9) stage_byte(8'hff);
        stage_byte(8'h7f);
        // not shortest form: trailing zero group at both ends of the range
        repeat (9) stage_byte(8'h80);
        stage_byte(8'h00);
        stage_byte(8'h80);
        stage_byte(8'h00);
        // top bit only, from a tenth byte of one
        repeat (9) stage_byte(8'h80);
        stage_byte(8'h01);
        send_burst();
    endtask

    task automatic test_value_limit();
        set_mode(1'b0, 64'd1000);
        send_value(64'd1000);
        send_value(64'd1001);
        set_mode(1'b0, 64'd0);
        send_value(64'd0);
        send_value(64'd1);
        // not shortest form wins over the limit
        stage_byte(8'h81);
        stage_byte(8'h00);
        send_burst();
    endtask

    task automatic test_zigzag();
        // limit stays at zero: it must be ignored here
        set_mode(1'b1, 64'd0);
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd2);
        send_value(64'd3);
        send_value('1);
        send_value(64'hffff_ffff_ffff_fffe);
    endtask

    task automatic test_config_mid_value();
        set_mode(1'b0, '1);
        send_byte(8'h85);
        wait_drain();
        cfg_write(REG_MAX_VALUE, 64'd100);
        send_byte(8'h01);
        send_byte(8'h81);
        wait_drain();
        cfg_write(REG_SIGNED_MODE, 64'd1);
        send_byte(8'h01);
    endtask

    task automatic run_random_phase(input logic sgn, input logic [63:0] lim,
                                    input int n_bytes, input logic no_idle,
                                    input logic pause_once);
        int   start;
        int   kind;
        logic paused;
        set_mode(sgn, lim);
        calm = no_idle;
        paused = 1'b0;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                queue_leb128(pick_value(), 0);
            else if (kind < 70)
                queue_leb128(pick_value(), $urandom_range(1, 3));
            else if (kind < 82)
            begin
                repeat (9) stage_byte(8'h80 | 8'($urandom_range(0, 127)));
                if ($urandom_range(0, 1) == 0)
                    stage_byte(8'($urandom_range(0, 3)));
                else
                    stage_byte(8'($urandom_range(0, 255)));
            end
            else
                repeat ($urandom_range(1, 4)) stage_byte(8'($urandom_range(0, 255)));
            send_burst();
            if (pause_once && !paused && bytes_sent - start > n_bytes / 2)
            begin
                paused = 1'b1;
                wait_drain();
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_random_stream();
        run_random_phase(1'b0, '1, 230, 1'b0, 1'b0);
        run_random_phase(1'b0, rand64(), 230, 1'b0, 1'b1);
        run_random_phase(1'b1, rand64(), 230, 1'b1, 1'b0);
        run_random_phase(1'b0, 64'd0, 230, 1'b0, 1'b0);
        run_random_phase(1'b0, 64'($urandom_range(0, 16383)), 230, 1'b0, 1'b0);
        run_random_phase(1'b1, '1, 230, 1'b0, 1'b0);
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value %h status %s",
                         $time, decoded_value, status.name());
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (decoded_value !== want.value)
                begin
                    $display("%0t: decoded_value expected %h actual %h",
                             $time, want.value, decoded_value);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %s actual %s",
                             $time, want.status.name(), status.name());
                    errors++;
                end
            end
        end
        out_ready <= calm || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_values();
        test_error_codes();
        test_value_limit();
        test_zigzag();
        test_config_mid_value();
        test_random_stream();
        wait_drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
